FILE: rtl/core/lpr_pkg.sv
// Shared constants and result type for the LRU page replacement block.
package lpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int CFG_W       = 4;
  localparam int FRAME_IDX_W = 3;
  localparam int FAULT_W     = 16;

  localparam logic [CFG_W-1:0]   FRAMES_RESET = CFG_W'(3);
  localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [FAULT_W-1:0]     fault_count;
    logic                   sequence_done;
  } result_t;

endpackage

FILE: rtl/core/lpr_channels.sv
// Valid/ready channel interfaces: page references, results and configuration.
interface lpr_ref_if #(
  parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 last_reference;

  modport source (output valid, page, last_reference, input ready);
  modport sink   (input valid, page, last_reference, output ready);
endinterface

interface lpr_result_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic [lpr_pkg::FRAME_IDX_W-1:0]     frame_index;
  logic [lpr_pkg::FAULT_W-1:0]         fault_count;
  logic                                sequence_done;

  modport source (output valid, hit, frame_index, fault_count, sequence_done, input ready);
  modport sink   (input valid, hit, frame_index, fault_count, sequence_done, output ready);
endinterface

interface lpr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [lpr_pkg::CFG_W-1:0]   frames_in_use;

  modport source (output valid, frames_in_use, input ready);
  modport sink   (input valid, frames_in_use, output ready);
endinterface

FILE: rtl/core/lpr_result_buf.sv
// Two-entry result buffer: holds results while the consumer stalls.
module lpr_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  lpr_pkg::result_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output lpr_pkg::result_t pop_data
);

  lpr_pkg::result_t entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/lru_page_replacement.sv
// LRU page replacement: per-reference hit/fill decision with rank-based recency.
// The result is registered in the result buffer before it shows on the result channel.
// Throughput: one reference per cycle while the result buffer has room; tag compare,
//   victim pick and rank update all settle in the accept cycle against the frame registers.
// A two-entry result buffer lets references keep flowing while one result waits.
// Reset (rst, synchronous): frames empty, ranks and fault count zero, frames_in_use = 3.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lpr_ref_if.sink   refs,
  lpr_result_if.source result,
  lpr_cfg_if.sink   cfg
);

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

  // ---------------------------------------------------------------------------
  // Configuration: number of managed frames, writable any time (always ready).
  // ---------------------------------------------------------------------------
  logic [lpr_pkg::CFG_W-1:0] frames_in_use;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lpr_pkg::FRAMES_RESET;
    end else if (cfg.valid) begin
      frames_in_use <= cfg.frames_in_use;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state. Page tags have no reset; a tag is only looked at when its
  // valid bit is set.
  // ---------------------------------------------------------------------------
  logic [PAGE_BITS-1:0]     frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]    frame_valid;
  logic [RANK_W-1:0]        rank       [MAX_FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] faults;

  logic [MAX_FRAMES-1:0]    frame_valid_next;
  logic [RANK_W-1:0]        rank_next  [MAX_FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] faults_next;
  logic [lpr_pkg::FAULT_W-1:0] fault_count;

  // ---------------------------------------------------------------------------
  // Lookup and replacement decision
  // ---------------------------------------------------------------------------
  logic                  accept;
  logic [PAGE_BITS-1:0]  page;
  logic [MAX_FRAMES-1:0] active;    // frame is within frames_in_use (0 counts as 1)
  logic [MAX_FRAMES-1:0] hit_vec;
  logic [MAX_FRAMES-1:0] empty_vec;
  logic                  hit;
  logic                  any_empty;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      empty_idx;
  logic [IDX_W-1:0]      victim_idx;
  logic [IDX_W-1:0]      sel;
  logic [RANK_W-1:0]     age_limit;
  logic                  age_all;   // filling an empty frame ages every other valid active frame

  assign page   = refs.page;
  assign accept = refs.valid && refs.ready;

  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      active[j]    = (j == 0) || (32'(j) < 32'(frames_in_use));
      hit_vec[j]   = active[j] && frame_valid[j] && (frame_page[j] == page);
      empty_vec[j] = active[j] && !frame_valid[j];
    end
    hit       = |hit_vec;
    any_empty = |empty_vec;

    // lowest index wins: scan from the top down
    hit_idx   = '0;
    empty_idx = '0;
    for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_idx = IDX_W'(j);
      end
      if (empty_vec[j]) begin
        empty_idx = IDX_W'(j);
      end
    end

    // oldest active frame, ties to the lowest index
    victim_idx = '0;
    for (int j = 1; j < MAX_FRAMES; j++) begin
      if (active[j] && (rank[j] > rank[victim_idx])) begin
        victim_idx = IDX_W'(j);
      end
    end

    priority if (hit) begin
      sel       = hit_idx;
      age_all   = 1'b0;
      age_limit = rank[hit_idx];
    end else if (any_empty) begin
      sel       = empty_idx;
      age_all   = 1'b1;
      age_limit = rank[empty_idx];
    end else begin
      sel       = victim_idx;
      age_all   = 1'b0;
      age_limit = rank[victim_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int j = 0; j < MAX_FRAMES; j++) begin
      rank_next[j] = rank[j];
      if (IDX_W'(j) == sel) begin
        rank_next[j] = '0;
      end else if (active[j] && frame_valid[j] && (age_all || (rank[j] < age_limit))
                   && (rank[j] != RANK_MAX)) begin
        rank_next[j] = rank[j] + RANK_W'(1);
      end
    end

    frame_valid_next      = frame_valid;
    frame_valid_next[sel] = 1'b1;

    if (hit || (faults == lpr_pkg::FAULT_MAX)) begin
      fault_count = faults;
    end else begin
      fault_count = faults + lpr_pkg::FAULT_W'(1);
    end

    // end of sequence: report first, then forget everything but the config
    if (refs.last_reference) begin
      frame_valid_next = '0;
      faults_next      = '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        rank_next[j] = '0;
      end
    end else begin
      faults_next = fault_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      faults      <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        rank[j] <= '0;
      end
    end else if (accept) begin
      frame_valid <= frame_valid_next;
      faults      <= faults_next;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        rank[j] <= rank_next[j];
      end
    end
  end

  // tag written only on a fill
  always_ff @(posedge clk) begin
    if (accept && !hit) begin
      frame_page[sel] <= page;
    end
  end

  // ---------------------------------------------------------------------------
  // Result path
  // ---------------------------------------------------------------------------
  lpr_pkg::result_t res_in;
  lpr_pkg::result_t res_out;

  always_comb begin
    res_in.hit           = hit;
    res_in.frame_index   = lpr_pkg::FRAME_IDX_W'(sel);
    res_in.fault_count   = fault_count;
    res_in.sequence_done = refs.last_reference;
  end

  lpr_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (refs.valid),
    .push_ready (refs.ready),
    .push_data  (res_in),
    .pop_valid  (result.valid),
    .pop_ready  (result.ready),
    .pop_data   (res_out)
  );

  assign result.hit           = res_out.hit;
  assign result.frame_index   = res_out.frame_index;
  assign result.fault_count   = res_out.fault_count;
  assign result.sequence_done = res_out.sequence_done;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && refs.last_reference |=> (frame_valid == '0) && (faults == '0))
    else $error("state not cleared after end of sequence");

  a_fault_counts: assert property (@(posedge clk) disable iff (rst)
    accept && !refs.last_reference && !hit |=> faults != '0)
    else $error("fault not counted");

  a_sel_most_recent: assert property (@(posedge clk) disable iff (rst)
    accept && !refs.last_reference |=> frame_valid[$past(sel)] && (rank[$past(sel)] == '0))
    else $error("referenced frame not valid and most recent");

endmodule

FILE: dv/lru_page_replacement_test.sv
// Testbench for lru_page_replacement: queue-fed driver, checking monitor, LRU predictor.
`timescale 1ns / 100ps

module lru_page_replacement_test;

  localparam int FRAMES    = lpr_pkg::MAX_FRAMES_DEF;
  localparam int PAGE_W    = lpr_pkg::PAGE_BITS_DEF;
  localparam int RANK_TOP  = FRAMES - 1;
  localparam int HOLD_LEN  = 80;    // long receiver hold-off, in cycles
  localparam int IDLE_MAX  = 4000;  // cycles with no handshake before giving up
  localparam int PHASE_LEN = 80;    // random references per configuration phase

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
  } page_ref_t;

  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lpr_ref_if #(.PAGE_BITS(PAGE_W)) page_ch ();
  lpr_result_if                    result_ch ();
  lpr_cfg_if                       cfg_ch ();

  lru_page_replacement dut (
    .clk    (clk),
    .rst    (rst),
    .refs   (page_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // references waiting to be offered, and results owed by the block
  page_ref_t         ref_queue [$];
  lpr_pkg::result_t  owed_results [$];
  page_ref_t         in_flight;

  int mismatches = 0;
  bit calm = 1'b0;        // set for the tail of the run: no idling on either side
  bit hold_req = 1'b0;    // asks the receiver for one long hold-off
  bit hold_taken = 1'b0;  // receiver has started that hold-off

  // ---------------------------------------------------------------------
  // LRU predictor: own copy of frames, ranks, fault tally and frame count.
  // Rank 0 is the newest; ranks saturate at RANK_TOP.
  // ---------------------------------------------------------------------
  logic [PAGE_W-1:0]           frm_page [FRAMES];
  logic                        frm_valid [FRAMES];
  logic [2:0]                  frm_rank [FRAMES];
  logic [lpr_pkg::FAULT_W-1:0] fault_tally;
  logic [lpr_pkg::CFG_W-1:0]   cfg_frames;

  function automatic void clear_frames();
    for (int j = 0; j < FRAMES; j++) begin
      frm_valid[j] = 1'b0;
      frm_rank[j]  = '0;
    end
    fault_tally = '0;
  endfunction

  // frame f becomes newest; valid active frames younger than limit age by one
  function automatic void age_others(int f, int limit, int n);
    for (int j = 0; j < n; j++) begin
      if (j != f && frm_valid[j] && int'(frm_rank[j]) < limit && int'(frm_rank[j]) < RANK_TOP)
        frm_rank[j] = frm_rank[j] + 3'd1;
    end
    frm_rank[f] = '0;
  endfunction

  function automatic lpr_pkg::result_t lru_reference(logic [PAGE_W-1:0] pg, logic is_last);
    lpr_pkg::result_t r;
    int               n;
    int               f;
    logic             found;
    logic             vacant;
    n = int'(cfg_frames);
    if (n == 0) n = 1;             // zero frames behaves as one
    if (n > FRAMES) n = FRAMES;    // oversize count clamps
    f = 0;
    found = 1'b0;
    vacant = 1'b0;
    // lowest-numbered active frame holding the page wins
    for (int j = 0; j < n; j++) begin
      if (!found && frm_valid[j] && frm_page[j] == pg) begin
        f = j;
        found = 1'b1;
      end
    end
    if (found) begin
      age_others(f, int'(frm_rank[f]), n);
    end else begin
      // fill the lowest empty frame first, else evict oldest rank (ties low)
      for (int j = 0; j < n; j++) begin
        if (!vacant && !frm_valid[j]) begin
          f = j;
          vacant = 1'b1;
        end
      end
      if (vacant) begin
        age_others(f, RANK_TOP + 1, n);
      end else begin
        f = 0;
        for (int j = 1; j < n; j++)
          if (frm_rank[j] > frm_rank[f]) f = j;
        age_others(f, int'(frm_rank[f]), n);
      end
      frm_page[f]  = pg;
      frm_valid[f] = 1'b1;
      if (fault_tally != lpr_pkg::FAULT_MAX)
        fault_tally = fault_tally + lpr_pkg::FAULT_W'(1);
    end
    r.hit           = found;
    r.frame_index   = lpr_pkg::FRAME_IDX_W'(f);
    r.fault_count   = fault_tally;
    r.sequence_done = is_last;
    if (is_last) clear_frames();  // result reports the total, then state clears
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued references, predicts each one at acceptance.
  // ---------------------------------------------------------------------
  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      page_ch.valid          <= 1'b0;
      page_ch.page           <= '0;
      page_ch.last_reference <= 1'b0;
      src_gap = 0;
      clear_frames();
      for (int j = 0; j < FRAMES; j++) frm_page[j] = '0;
    end else begin
      if (page_ch.valid && page_ch.ready)
        owed_results.push_back(lru_reference(in_flight.page, in_flight.last));
      // slot is free when nothing is offered or the offer just went through
      if (!page_ch.valid || page_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          page_ch.valid <= 1'b0;
        end else if (ref_queue.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 4);  // start an idle burst before the next reference
          page_ch.valid <= 1'b0;
        end else if (ref_queue.size() != 0) begin
          in_flight = ref_queue.pop_front();
          page_ch.valid          <= 1'b1;
          page_ch.page           <= in_flight.page;
          page_ch.last_reference <= in_flight.last;
        end else begin
          page_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random backpressure, checks every accepted result in order.
  // ---------------------------------------------------------------------
  int sink_gap = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    lpr_pkg::result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_gap = 0;
      hold_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result item: hit %0d frame %0d faults %0d done %0d",
                 result_ch.hit, result_ch.frame_index, result_ch.fault_count,
                 result_ch.sequence_done);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (result_ch.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, result_ch.hit);
            mismatches++;
          end
          if (result_ch.frame_index !== want.frame_index) begin
            $error("frame_index: expected %0d, actual %0d",
                   want.frame_index, result_ch.frame_index);
            mismatches++;
          end
          if (result_ch.fault_count !== want.fault_count) begin
            $error("fault_count: expected %0d, actual %0d",
                   want.fault_count, result_ch.fault_count);
            mismatches++;
          end
          if (result_ch.sequence_done !== want.sequence_done) begin
            $error("sequence_done: expected %0d, actual %0d",
                   want.sequence_done, result_ch.sequence_done);
            mismatches++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_left = HOLD_LEN;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        result_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 4);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: no handshake on any channel for too long ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((page_ch.valid && page_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_MAX) begin
      $display("lru_page_replacement_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_ref(logic [PAGE_W-1:0] pg, logic is_last);
    page_ref_t item;
    item.page = pg;
    item.last = is_last;
    ref_queue.push_back(item);
  endtask

  // sampled on the falling edge so queue updates of the clocked blocks are settled
  task automatic wait_idle();
    do @(negedge clk);
    while (ref_queue.size() != 0 || page_ch.valid || owed_results.size() != 0);
  endtask

  // frame count write, only once the block has drained
  task automatic write_frames(logic [lpr_pkg::CFG_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.frames_in_use <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_frames = v;
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // mostly well-formed sequences over a small page pool (for hits and
  // evictions), the rest single random references
  task automatic make_traffic(int count);
    int                made;
    int                run_len;
    int                pool_n;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pool [12];
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 85) begin
        run_len = $urandom_range(1, 40);
        pool_n  = $urandom_range(1, 12);
        base    = PAGE_W'($urandom);
        for (int k = 0; k < pool_n; k++) pool[k] = base ^ PAGE_W'($urandom_range(0, 63));
        for (int k = 0; k < run_len && made < count; k++) begin
          push_ref(pool[$urandom_range(0, pool_n - 1)], k == run_len - 1);
          made++;
        end
      end else begin
        push_ref(PAGE_W'($urandom), $urandom_range(0, 7) == 0);
        made++;
      end
    end
  endtask

  int frame_plan [14] = '{5, 1, 8, 2, 7, 0, 15, 4, 6, 3, 9, 8, 2, 12};

  initial begin
    cfg_frames             = lpr_pkg::FRAMES_RESET;
    rst                    <= 1'b1;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.frames_in_use   <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset frame count of 3, fills, hits, LRU eviction
    push_ref(16'h0000, 1'b0);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h5555, 1'b0);
    push_ref(16'h0000, 1'b0);
    push_ref(16'hAAAA, 1'b0);  // evicts the oldest frame
    push_ref(16'h5555, 1'b0);
    push_ref(16'hFFFF, 1'b0);
    // growing the frame set: stale ranks, new empty frames fill first
    write_frames(4'd8);
    push_ref(16'hAAAA, 1'b0);
    push_ref(16'h8001, 1'b0);
    push_ref(16'h7FFE, 1'b0);
    // shrinking: resident pages outside the active range miss
    write_frames(4'd2);
    push_ref(16'h5555, 1'b0);
    push_ref(16'h8001, 1'b0);
    // regrowing: the same page in several frames, lowest one hits
    write_frames(4'd4);
    push_ref(16'h5555, 1'b0);
    push_ref(16'h1234, 1'b0);
    // zero count acts as one frame
    write_frames(4'd0);
    push_ref(16'h0000, 1'b0);
    push_ref(16'h0000, 1'b0);
    // oversize count clamps to all frames; end of sequence then reuse
    write_frames(4'd15);
    push_ref(16'hFFFF, 1'b0);
    push_ref(16'h4321, 1'b1);
    push_ref(16'h4321, 1'b0);
    push_ref(16'h4321, 1'b1);

    // random phases; each config change waits for the block to drain,
    // which also pauses the sender until all results are in
    foreach (frame_plan[p]) begin
      write_frames(lpr_pkg::CFG_W'(frame_plan[p]));
      if (p == 3) hold_req = 1'b1;  // receiver stalls while references pile up
      if (p >= 12) calm = 1'b1;
      make_traffic(PHASE_LEN);
    end

    wait_idle();
    repeat (4) @(posedge clk);  // room for any stray result after the last one
    if (mismatches == 0)
      $display("lru_page_replacement_test: PASS");
    else
      $display("lru_page_replacement_test: FAIL");
    $finish;
  end

endmodule
